// ===== hw/rtl/fsca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fsca_pkg;
    localparam int MAX_CHUNKS = 64;
    localparam int OWNER_BITS = 16;
    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic [1:0] REG_FIT_MODE = 2'd0;
    localparam logic [1:0] REG_POOL     = 2'd1;
    localparam logic [1:0] REG_HEADER   = 2'd2;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [23:0] request_bytes;
        logic [15:0] owner_tag;
        logic [7:0]  fill_mark;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] location;
    } t_out_item;

    // One table row.
    typedef struct packed {
        logic [23:0]           start;
        logic [23:0]           length;
        logic [OWNER_BITS-1:0] owner;
        logic                  is_free;
        logic [7:0]            mark;
        logic [IDX_W-1:0]      link;
    } t_chunk;

    // Table port: one read, one write per cycle.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_chunk           wr_data;
    } t_tbl_req;
endpackage
`default_nettype wire

// ===== hw/rtl/fsca_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fsca_table (
    input  wire logic              i_clk,
    input  wire fsca_pkg::t_tbl_req i_req,
    output fsca_pkg::t_chunk       o_rd_data
);
    fsca_pkg::t_chunk r_mem [fsca_pkg::MAX_CHUNKS];
    fsca_pkg::t_chunk r_rd;

    // Synchronous single-read single-write memory
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

// ===== hw/rtl/fsca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fsca_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fsca_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fsca_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    output fsca_pkg::t_tbl_req      o_tbl,
    input  wire fsca_pkg::t_chunk   i_rd_data
);
    localparam int IW = fsca_pkg::IDX_W;
    localparam int CW = fsca_pkg::CNT_W;

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_WALK, S_FETCH, S_SPLIT} t_state;

    t_state              r_state,   n_state;
    logic [1:0]          r_mode,    n_mode;
    logic [23:0]         r_pool,    n_pool;
    logic [11:0]         r_hdr,     n_hdr;
    logic [CW-1:0]       r_used,    n_used;
    fsca_pkg::t_in_item  r_item,    n_item;
    logic [CW-1:0]       r_n,       n_n;
    logic [IW-1:0]       r_cur,     n_cur;       // entry whose row is on i_rd_data
    logic                r_found,   n_found;
    logic [IW-1:0]       r_sel,     n_sel;
    logic [23:0]         r_sel_len, n_sel_len;
    fsca_pkg::t_chunk    r_row,     n_row;
    logic                r_split,   n_split;     // remainder row still to be written
    logic                r_out_v,   n_out_v;
    fsca_pkg::t_out_item r_out,     n_out;

    logic          hit;
    logic          better;
    logic          walk_end;
    logic [24:0]   thr;
    logic          in_acc;
    logic          cfg_acc;
    fsca_pkg::t_chunk new_row;

    // Input held off while a config transaction is offered, so both never land together
    assign in_acc  = i_in_valid && !o_in_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_v || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Candidate test on the row just read
    always_comb begin
        hit = 1'b0;
        better = 1'b0;
        if (r_item.kind == fsca_pkg::KIND_ALLOC) begin
            hit = i_rd_data.is_free && (i_rd_data.length >= r_item.request_bytes);
            unique case (r_mode)
                fsca_pkg::MODE_FIRST: better = !r_found;
                fsca_pkg::MODE_BEST:  better = !r_found || (i_rd_data.length < r_sel_len);
                fsca_pkg::MODE_WORST: better = !r_found || (i_rd_data.length > r_sel_len);
                default:              better = 1'b0;
            endcase
        end else begin
            hit = !i_rd_data.is_free &&
                  (i_rd_data.owner == r_item.owner_tag[fsca_pkg::OWNER_BITS-1:0]);
            better = 1'b1;
        end
        walk_end = (r_n + CW'(1) >= r_used) ||
                   (hit && better && (r_item.kind == fsca_pkg::KIND_RELEASE ||
                                      r_mode == fsca_pkg::MODE_FIRST));
        thr = {1'b0, r_item.request_bytes} + 25'(r_hdr);
    end

    // Table port
    always_comb begin
        new_row = '0;
        new_row.start   = r_row.start + r_item.request_bytes;
        new_row.length  = r_row.length - r_item.request_bytes;
        new_row.is_free = 1'b1;
        new_row.link    = r_row.link;
        o_tbl = '0;
        unique case (r_state)
            S_INIT: begin
                o_tbl.wr_en = 1'b1;
                o_tbl.wr_data.length  = (r_pool > 24'(r_hdr)) ? r_pool - 24'(r_hdr) : '0;
                o_tbl.wr_data.is_free = 1'b1;
            end
            S_IDLE: begin
                o_tbl.rd_en = in_acc;
            end
            S_WALK: begin
                // next entry each cycle; the chosen row once the walk stops
                o_tbl.rd_en   = 1'b1;
                o_tbl.rd_addr = i_rd_data.link;
                if (walk_end) begin
                    o_tbl.rd_addr = (hit && better) ? r_cur : r_sel;
                end
            end
            S_FETCH: begin
                if (r_found && r_item.kind == fsca_pkg::KIND_RELEASE) begin
                    o_tbl.wr_en   = 1'b1;
                    o_tbl.wr_addr = r_sel;
                    o_tbl.wr_data = i_rd_data;
                    o_tbl.wr_data.is_free = 1'b1;
                    o_tbl.wr_data.mark    = '0;
                end
            end
            S_SPLIT: begin
                o_tbl.wr_en = 1'b1;
                if (r_split) begin
                    o_tbl.wr_addr = IW'(r_used);
                    o_tbl.wr_data = new_row;
                end else begin
                    o_tbl.wr_addr = r_sel;
                    o_tbl.wr_data = r_row;
                end
            end
            default: ;
        endcase
    end

    // Sequencer next state: one list entry evaluated per cycle
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_pool    = r_pool;
        n_hdr     = r_hdr;
        n_used    = r_used;
        n_item    = r_item;
        n_n       = r_n;
        n_cur     = r_cur;
        n_found   = r_found;
        n_sel     = r_sel;
        n_sel_len = r_sel_len;
        n_row     = r_row;
        n_split   = r_split;
        n_out_v   = r_out_v;
        n_out     = r_out;
        if (r_out_v && !i_out_stall) n_out_v = 1'b0;
        unique case (r_state)
            S_INIT: begin
                n_used  = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_item  = i_in_data;
                    n_n     = '0;
                    n_cur   = '0;
                    n_found = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (hit && better) begin
                    n_found   = 1'b1;
                    n_sel     = r_cur;
                    n_sel_len = i_rd_data.length;
                end
                n_cur = i_rd_data.link;
                n_n   = r_n + CW'(1);
                if (walk_end) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_out_v = 1'b1;
                n_state = S_IDLE;
                if (!r_found) begin
                    n_out.status   = (r_item.kind == fsca_pkg::KIND_ALLOC) ?
                                     fsca_pkg::ST_NOFIT : fsca_pkg::ST_BADFREE;
                    n_out.location = '0;
                end else begin
                    n_out.status   = fsca_pkg::ST_OK;
                    n_out.location = i_rd_data.start;
                    if (r_item.kind == fsca_pkg::KIND_ALLOC) begin
                        n_row         = i_rd_data;
                        n_row.owner   = r_item.owner_tag[fsca_pkg::OWNER_BITS-1:0];
                        n_row.is_free = 1'b0;
                        n_row.mark    = r_item.fill_mark;
                        n_out_v       = 1'b0;
                        n_state       = S_SPLIT;
                        n_split       = ({1'b0, i_rd_data.length} > thr) &&
                                        (r_used < CW'(fsca_pkg::MAX_CHUNKS));
                    end
                end
            end
            S_SPLIT: begin
                if (r_split) begin
                    n_row.link   = IW'(r_used);
                    n_row.length = r_item.request_bytes;
                    n_used       = r_used + CW'(1);
                    n_split      = 1'b0;
                end else begin
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Register writes, only taken while idle
        if (cfg_acc) begin
            unique case (i_cfg_index)
                fsca_pkg::REG_FIT_MODE: n_mode = i_cfg_data[1:0];
                fsca_pkg::REG_POOL: begin
                    n_pool  = i_cfg_data;
                    n_state = S_INIT;
                end
                fsca_pkg::REG_HEADER:   n_hdr  = i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= fsca_pkg::MODE_FIRST;
            r_pool  <= 24'd65536;
            r_hdr   <= 12'd32;
            r_used  <= CW'(1);
            r_n     <= '0;
            r_cur   <= '0;
            r_found <= 1'b0;
            r_sel   <= '0;
            r_split <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_pool  <= n_pool;
            r_hdr   <= n_hdr;
            r_used  <= n_used;
            r_n     <= n_n;
            r_cur   <= n_cur;
            r_found <= n_found;
            r_sel   <= n_sel;
            r_split <= n_split;
            r_out_v <= n_out_v;
        end
        r_item    <= n_item;
        r_sel_len <= n_sel_len;
        r_row     <= n_row;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= CW'(1) && r_used <= CW'(fsca_pkg::MAX_CHUNKS))
        else $error("chunk count out of range");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> o_in_stall)
        else $error("input taken while result pending");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_n < r_used))
        else $error("walk exceeded table");
    a_fail_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status != fsca_pkg::ST_OK) |-> (r_out.location == '0))
        else $error("failure with nonzero location");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/fit_strategy_chunk_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A walk visits 1..MAX_CHUNKS list entries, one entry per cycle; the result is then set in
// FETCH (release or no fit) or in SPLIT (allocate), where SPLIT first writes the remainder row
// when an allocation is split.
// One transaction in flight: a new input is accepted only after the result has been taken.
// Reset (synchronous, active low) loads register defaults and then rewrites table entry 0 in
// S_INIT; a pool_bytes write also rewrites entry 0 through S_INIT.
module fit_strategy_chunk_allocator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fsca_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fsca_pkg::t_out_item     o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    fsca_pkg::t_tbl_req tbl;
    fsca_pkg::t_chunk   rd;

    fsca_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_tbl(tbl), .i_rd_data(rd)
    );

    fsca_table u_table (.i_clk, .i_req(tbl), .o_rd_data(rd));
endmodule
`default_nettype wire
